FILE: rtl/itoa_pkg.sv
// itoa_pkg: shared types, codes and the digit-to-ASCII function for the
// integer-to-ASCII formatter. No dependencies.
package itoa_pkg;

    // Conversion kinds carried in format_kind
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEX  = 3'd2;
    localparam logic [2:0] KIND_OCT  = 3'd3;
    localparam logic [2:0] KIND_BIN  = 3'd4;

    // Bit positions in flags
    localparam int FLG_LEFT  = 0;
    localparam int FLG_SIGN  = 1;
    localparam int FLG_SPACE = 2;
    localparam int FLG_ZERO  = 3;
    localparam int FLG_ALT   = 4;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ALPHA = 8'h37;   // 'A' - 10

    // Width of counts of characters and digits
    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_HEX,
        RDX_OCT,
        RDX_BIN
    } radix_t;

    typedef enum logic [1:0] {
        DG_HOLD,
        DG_LOAD,
        DG_DABBLE,
        DG_SHIFT
    } dig_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        dig_op_t op;
        radix_t  radix;
    } dig_ctrl_t;

    typedef struct packed {
        logic [7:0]       ascii;     // top digit as a character
        logic             top_zero;  // top digit is zero
        logic [CNT_W-1:0] remain;    // digits left in the register
    } dig_stat_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'b0, d};
        else
            c = CH_ALPHA + {4'b0, d};
        return c;
    endfunction

endpackage

FILE: rtl/itoa_digits.sv
// itoa_digits: digit register of the formatter. Binary to BCD by shift and
// add-3, one bit a cycle; digits leave most significant first. Uses itoa_pkg.
module itoa_digits #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  itoa_pkg::dig_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]   mag,
    output itoa_pkg::dig_stat_t     stat
);

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int DW         = 4 * DEC_DIGITS;
    localparam int EXT        = DW - VALUE_BITS;

    logic [DW-1:0]               dig_reg, dig_next;
    logic [VALUE_BITS-1:0]       bin_reg, bin_next;
    logic [itoa_pkg::CNT_W-1:0]  rem_reg, rem_next;
    itoa_pkg::radix_t            rdx_reg, rdx_next;
    logic [DW-1:0]               adj;
    logic [DW-1:0]               mag_ext;
    logic [3:0]                  top;

    assign mag_ext = {{EXT{1'b0}}, mag};

    // add 3 to every BCD nibble at or above 5 before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        unique case (rdx_reg)
            itoa_pkg::RDX_BIN: top = {3'b0, dig_reg[DW-1]};
            itoa_pkg::RDX_OCT: top = {1'b0, dig_reg[DW-1 -: 3]};
            default:           top = dig_reg[DW-1 -: 4];
        endcase
    end

    always_comb
    begin
        dig_next = dig_reg;
        bin_next = bin_reg;
        rem_next = rem_reg;
        rdx_next = rdx_reg;
        unique case (ctrl.op)
            itoa_pkg::DG_LOAD:
            begin
                rdx_next = ctrl.radix;
                bin_next = mag;
                unique case (ctrl.radix)
                    itoa_pkg::RDX_DEC:
                    begin
                        dig_next = '0;
                        rem_next = itoa_pkg::CNT_W'(DEC_DIGITS);
                    end
                    itoa_pkg::RDX_HEX:
                    begin
                        dig_next = mag_ext << (DW - 4 * HEX_DIGITS);
                        rem_next = itoa_pkg::CNT_W'(HEX_DIGITS);
                    end
                    itoa_pkg::RDX_OCT:
                    begin
                        dig_next = mag_ext << (DW - 3 * OCT_DIGITS);
                        rem_next = itoa_pkg::CNT_W'(OCT_DIGITS);
                    end
                    default:
                    begin
                        dig_next = mag_ext << EXT;
                        rem_next = itoa_pkg::CNT_W'(VALUE_BITS);
                    end
                endcase
            end
            itoa_pkg::DG_DABBLE:
            begin
                dig_next = {adj[DW-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = bin_reg << 1;
            end
            itoa_pkg::DG_SHIFT:
            begin
                unique case (rdx_reg)
                    itoa_pkg::RDX_BIN: dig_next = dig_reg << 1;
                    itoa_pkg::RDX_OCT: dig_next = dig_reg << 3;
                    default:           dig_next = dig_reg << 4;
                endcase
                rem_next = rem_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            rdx_reg <= itoa_pkg::RDX_DEC;
        end
        else
        begin
            rem_reg <= rem_next;
            rdx_reg <= rdx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign stat.ascii    = itoa_pkg::digit_ascii(top);
    assign stat.top_zero = (top == 4'd0);
    assign stat.remain   = rem_reg;

endmodule

FILE: rtl/integer_to_ascii_formatter_unit.sv
// integer_to_ascii_formatter_unit: printf-style integer conversion to a run
// of ASCII characters. Uses itoa_pkg and itoa_digits.
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+-------------------------
//  command  | value format_kind short_length flags field_width | start & !busy
//  result   | character last total_chars                      | strobe, one cycle, no stall
//
// Steps: an item is loaded, then decimal kinds pass all VALUE_BITS bits
// through shift/add-3 (hex, octal and binary skip this), leading zero
// digits are dropped one at a time, and one character per cycle is emitted.
// The BCD loop and the character output set the run time.
// Reset clears all control state; the unit is then idle. An unknown kind is
// ignored: the unit stays idle and produces no characters. Results cannot be held off.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [2:0]  format_kind,
    input  logic        short_length,
    input  logic [4:0]  flags,
    input  logic [5:0]  field_width,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last,
    output logic [5:0]  total_chars
);

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int NW = itoa_pkg::CNT_W;

    itoa_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        cyc_reg, cyc_next;        // BCD steps left
    logic [4:0]           flags_reg, flags_next;
    logic [NW-1:0]        width_reg, width_next;    // saturated field width
    logic [1:0]           plen_reg, plen_next;      // prefix chars left
    logic [15:0]          pre_reg, pre_next;        // prefix, first char on top
    logic [NW-1:0]        lead_reg, lead_next;      // spaces before prefix
    logic [NW-1:0]        zpad_reg, zpad_next;      // zeros after prefix
    logic [NW-1:0]        trail_reg, trail_next;    // spaces after digits
    logic [NW-1:0]        sent_reg, sent_next;
    logic [NW-1:0]        tot_reg, tot_next;

    logic                 strobe_reg, strobe_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic [NW-1:0]        total_reg, total_next;

    itoa_pkg::dig_ctrl_t  dctrl;
    itoa_pkg::dig_stat_t  dstat;

    // magnitude of the argument, after truncation and sign handling
    logic [VALUE_BITS-1:0] v_ext, v_mask, mag;
    logic                  neg;
    logic [NW:0]           count;
    logic [NW-1:0]         pad;

    assign v_mask = short_length ? VALUE_BITS'(17'h0FFFF) : '1;
    assign v_ext  = value[VALUE_BITS-1:0] & v_mask;
    assign neg    = (format_kind == itoa_pkg::KIND_SDEC) &&
                    (short_length ? value[15] : value[VALUE_BITS-1]);
    assign mag    = neg ? ((~v_ext + 1'b1) & v_mask) : v_ext;

    // run length once the digit count is known
    assign count = {{(NW-1){1'b0}}, plen_reg} + {1'b0, dstat.remain};
    assign pad   = ({1'b0, width_reg} > count) ? NW'({1'b0, width_reg} - count) : '0;

    always_comb
    begin
        state_next  = state_reg;
        cyc_next    = cyc_reg;
        flags_next  = flags_reg;
        width_next  = width_reg;
        plen_next   = plen_reg;
        pre_next    = pre_reg;
        lead_next   = lead_reg;
        zpad_next   = zpad_reg;
        trail_next  = trail_reg;
        sent_next   = sent_reg;
        tot_next    = tot_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        total_next  = total_reg;
        dctrl.op    = itoa_pkg::DG_HOLD;
        dctrl.radix = itoa_pkg::RDX_DEC;

        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (start && format_kind <= itoa_pkg::KIND_BIN)
                begin
                    dctrl.op   = itoa_pkg::DG_LOAD;
                    flags_next = flags;
                    width_next = (field_width > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH)
                                                                : field_width;
                    cyc_next   = CW'(VALUE_BITS);
                    plen_next  = 2'd0;
                    pre_next   = '0;
                    case (format_kind)
                        itoa_pkg::KIND_HEX: dctrl.radix = itoa_pkg::RDX_HEX;
                        itoa_pkg::KIND_OCT: dctrl.radix = itoa_pkg::RDX_OCT;
                        itoa_pkg::KIND_BIN: dctrl.radix = itoa_pkg::RDX_BIN;
                        default:            dctrl.radix = itoa_pkg::RDX_DEC;
                    endcase
                    if (format_kind == itoa_pkg::KIND_SDEC)
                    begin
                        if (neg)
                        begin
                            plen_next = 2'd1;
                            pre_next  = {itoa_pkg::CH_MINUS, 8'h00};
                        end
                        else if (flags[itoa_pkg::FLG_SIGN])
                        begin
                            plen_next = 2'd1;
                            pre_next  = {itoa_pkg::CH_PLUS, 8'h00};
                        end
                        else if (flags[itoa_pkg::FLG_SPACE])
                        begin
                            plen_next = 2'd1;
                            pre_next  = {itoa_pkg::CH_SPACE, 8'h00};
                        end
                    end
                    else if (flags[itoa_pkg::FLG_SIGN])
                    begin
                        plen_next = 2'd1;
                        pre_next  = {itoa_pkg::CH_PLUS, 8'h00};
                    end
                    else if (flags[itoa_pkg::FLG_ALT] && format_kind == itoa_pkg::KIND_HEX)
                    begin
                        plen_next = 2'd2;
                        pre_next  = {itoa_pkg::CH_ZERO, itoa_pkg::CH_X};
                    end
                    else if (flags[itoa_pkg::FLG_ALT] && format_kind == itoa_pkg::KIND_OCT)
                    begin
                        plen_next = 2'd1;
                        pre_next  = {itoa_pkg::CH_ZERO, 8'h00};
                    end
                    if (format_kind == itoa_pkg::KIND_SDEC ||
                        format_kind == itoa_pkg::KIND_UDEC)
                        state_next = itoa_pkg::ST_CONV;
                    else
                        state_next = itoa_pkg::ST_NORM;
                end
            end

            itoa_pkg::ST_CONV:
            begin
                dctrl.op = itoa_pkg::DG_DABBLE;
                cyc_next = cyc_reg - 1'b1;
                if (cyc_reg == CW'(1))
                    state_next = itoa_pkg::ST_NORM;
            end

            itoa_pkg::ST_NORM:
            begin
                // drop leading zero digits, keep at least one
                if (dstat.remain > NW'(1) && dstat.top_zero)
                    dctrl.op = itoa_pkg::DG_SHIFT;
                else
                begin
                    lead_next  = '0;
                    zpad_next  = '0;
                    trail_next = '0;
                    if (flags_reg[itoa_pkg::FLG_LEFT])
                        trail_next = pad;
                    else if (flags_reg[itoa_pkg::FLG_ZERO])
                        zpad_next = pad;
                    else
                        lead_next = pad;
                    tot_next   = NW'(count) + pad;
                    sent_next  = '0;
                    state_next = itoa_pkg::ST_EMIT;
                end
            end

            itoa_pkg::ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (lead_reg != '0)
                begin
                    char_next = itoa_pkg::CH_SPACE;
                    lead_next = lead_reg - 1'b1;
                end
                else if (plen_reg != 2'd0)
                begin
                    char_next = pre_reg[15:8];
                    pre_next  = pre_reg << 8;
                    plen_next = plen_reg - 1'b1;
                end
                else if (zpad_reg != '0)
                begin
                    char_next = itoa_pkg::CH_ZERO;
                    zpad_next = zpad_reg - 1'b1;
                end
                else if (dstat.remain != '0)
                begin
                    char_next = dstat.ascii;
                    dctrl.op  = itoa_pkg::DG_SHIFT;
                end
                else
                begin
                    char_next  = itoa_pkg::CH_SPACE;
                    trail_next = trail_reg - 1'b1;
                end
                sent_next = sent_reg + 1'b1;
                if (sent_reg + 1'b1 == tot_reg)
                begin
                    last_next  = 1'b1;
                    total_next = tot_reg;
                    state_next = itoa_pkg::ST_IDLE;
                end
                else
                begin
                    last_next  = 1'b0;
                    total_next = '0;
                end
            end

            default: state_next = itoa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itoa_pkg::ST_IDLE;
            cyc_reg    <= '0;
            plen_reg   <= '0;
            lead_reg   <= '0;
            zpad_reg   <= '0;
            trail_reg  <= '0;
            sent_reg   <= '0;
            tot_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cyc_reg    <= cyc_next;
            plen_reg   <= plen_next;
            lead_reg   <= lead_next;
            zpad_reg   <= zpad_next;
            trail_reg  <= trail_next;
            sent_reg   <= sent_next;
            tot_reg    <= tot_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        width_reg <= width_next;
        pre_reg   <= pre_next;
        char_reg  <= char_next;
    end

    itoa_digits #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctrl),
        .mag   (mag),
        .stat  (dstat)
    );

    assign busy        = (state_reg != itoa_pkg::ST_IDLE);
    assign strobe      = strobe_reg;
    assign character   = char_reg;
    assign last        = last_reg;
    assign total_chars = total_reg;

    // the run ends exactly when the unit goes idle
    a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("busy dropped without a final character");

    // a character outside a busy period must close the run
    a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("character emitted after the run ended");

    // count shows only on the final character, and is never zero there
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last ? (total_chars != '0) : (total_chars == '0)))
        else $error("total_chars wrong for last flag");

endmodule
